// File: rtl/spectrum_bar_peak_hold_top_defines.svh
// Assertion helpers used by the top-level RTL.
`ifndef SPECTRUM_BAR_PEAK_HOLD_TOP_DEFINES_SVH
`define SPECTRUM_BAR_PEAK_HOLD_TOP_DEFINES_SVH

// cond must never hold outside reset
`define SBPH_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// trig at one edge implies res at the next
`define SBPH_ASSERT_NEXT(lbl, clk, rst, trig, res, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (res)) else $error(msg);

`endif

// File: rtl/sbph_pkg.sv
`timescale 1ns / 1ps
package sbph_pkg;

   localparam int NumColumns = 128;
   localparam int ColW       = 7;
   localparam int ColAddrW   = $clog2(NumColumns);
   localparam int CompW      = 16;
   localparam int MagW       = 17;
   localparam int RowW       = 6;
   localparam int PeakW      = 7;
   localparam int DivW       = 8;
   localparam int FallW      = 3;
   localparam int QuotW      = 6;
   localparam int QDepth     = 32;
   localparam int QPtrW      = $clog2(QDepth);
   localparam int QCntW      = $clog2(QDepth + 1);
   localparam int CsrIdxW    = 2;
   localparam int CsrDataW   = 8;

   localparam logic [RowW-1:0] FullLimit = 6'd63;
   localparam logic [RowW-1:0] HalfLimit = 6'd31;
   localparam logic [RowW-1:0] BarGap    = 6'd2;

   localparam logic [CsrIdxW-1:0] CsrDivisor    = 2'd0;
   localparam logic [CsrIdxW-1:0] CsrFallStep   = 2'd1;
   localparam logic [CsrIdxW-1:0] CsrHalfHeight = 2'd2;

   localparam logic [DivW-1:0]  DivisorReset  = 8'd10;
   localparam logic [FallW-1:0] FallStepReset = 3'd2;

   typedef struct packed {
      logic [DivW-1:0]  divisor;
      logic [FallW-1:0] fall_step;
      logic             half_height;
   } cfg_type;

   typedef struct packed {
      logic signed [CompW-1:0] re_part;
      logic signed [CompW-1:0] im_part;
      logic [ColW-1:0]         column;
      logic                    is_dc;
   } in_word_type;

   typedef struct packed {
      logic [MagW-1:0] magnitude;
      logic [RowW-1:0] bar_top;
      logic [ColW-1:0] column;
   } bar_word_type;

   typedef struct packed {
      logic             nonempty;
      logic [QCntW-1:0] count;
   } q_status_type;

endpackage

// File: rtl/sbph_req_if.sv
`timescale 1ns / 1ps
interface sbph_req_if;
   import sbph_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [CompW-1:0] re_part;
   logic signed [CompW-1:0] im_part;
   logic [ColW-1:0]         column;
   logic                    is_dc;
   modport source (output valid, re_part, im_part, column, is_dc, input ready);
   modport sink (input valid, re_part, im_part, column, is_dc, output ready);
endinterface

// File: rtl/sbph_rsp_if.sv
`timescale 1ns / 1ps
interface sbph_rsp_if;
   import sbph_pkg::*;
   logic            valid;
   logic            ready;
   logic [MagW-1:0] magnitude;
   logic [RowW-1:0] bar_top;
   logic            peak_visible;
   logic [RowW-1:0] peak_row;
   modport source (output valid, magnitude, bar_top, peak_visible, peak_row, input ready);
   modport sink (input valid, magnitude, bar_top, peak_visible, peak_row, output ready);
endinterface

// File: rtl/spectrum_bar_peak_hold_top.sv
// Spectrum bar with falling peak hold. One bin word enters per cycle when req.ready
// is high; ready drops only while 32 words are held between the compute pipeline
// and the 32-word queue. Each word passes the front pipeline (two 16x16 squarers,
// a 17-stage square root, a 6-stage divide), waits in the queue, then passes the
// peak stage (registered read of the 128-entry peak RAM, then the update with
// write-to-read forwarding) before its result word appears. Peak RAM entries never
// written read as 63 through per-column valid bits, so no clearing pass runs after
// reset.
`timescale 1ns / 1ps
`include "spectrum_bar_peak_hold_top_defines.svh"
module spectrum_bar_peak_hold_top (
   input  logic                           clock,
   input  logic                           reset,
   sbph_req_if.sink                       req,
   sbph_rsp_if.source                     rsp,
   input  logic                           csr_wr_en,
   input  logic [sbph_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [sbph_pkg::CsrDataW-1:0]  csr_data
);
   import sbph_pkg::*;

   cfg_type          cfg_ff;
   logic [QCntW-1:0] cnt_ff;
   logic             accept, pop, f_vld;
   in_word_type      in_word;
   bar_word_type     f_word, head;
   q_status_type     q_stat;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.divisor <= DivisorReset;
         cfg_ff.fall_step <= FallStepReset;
         cfg_ff.half_height <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CsrDivisor:    cfg_ff.divisor <= csr_data[DivW-1:0];
            CsrFallStep:   cfg_ff.fall_step <= csr_data[FallW-1:0];
            CsrHalfHeight: cfg_ff.half_height <= csr_data[0];
            default: ;
         endcase
      end
   end

   // words accepted and not yet popped from the queue
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_ff + QCntW'(accept) - QCntW'(pop);
      end
   end

   assign req.ready = cnt_ff < QCntW'(QDepth);
   assign accept = req.valid && req.ready;
   assign in_word.re_part = req.re_part;
   assign in_word.im_part = req.im_part;
   assign in_word.column = req.column;
   assign in_word.is_dc = req.is_dc;

   sbph_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (accept),
      .in_word  (in_word),
      .cfg      (cfg_ff),
      .out_vld  (f_vld),
      .out_word (f_word)
   );

   sbph_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_vld),
      .push_word (f_word),
      .pop       (pop),
      .head      (head),
      .status    (q_stat)
   );

   sbph_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .head_vld (q_stat.nonempty),
      .pop      (pop),
      .cfg      (cfg_ff),
      .rsp      (rsp)
   );

   `SBPH_ASSERT_NEVER(a_credit_bound, clock, reset, cnt_ff > QCntW'(QDepth), "credit overrun")
   `SBPH_ASSERT_NEVER(a_queue_within_credit, clock, reset, q_stat.count > cnt_ff, "queue exceeds credit")
   `SBPH_ASSERT_NEXT(a_accept_counted, clock, reset, accept, cnt_ff != '0, "accepted word not counted")
   `SBPH_ASSERT_NEVER(a_pop_nonempty, clock, reset, pop && !q_stat.nonempty, "pop from empty queue")
endmodule

// File: rtl/sbph_ram.sv
`timescale 1ns / 1ps
module sbph_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// File: rtl/sbph_front.sv
`timescale 1ns / 1ps
module sbph_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_vld,
   input  sbph_pkg::in_word_type  in_word,
   input  sbph_pkg::cfg_type      cfg,
   output logic                   out_vld,
   output sbph_pkg::bar_word_type out_word
);
   import sbph_pkg::*;

   localparam int SqW       = 2 * CompW;
   localparam int RadW      = SqW + 3;
   localparam int SqrtSteps = MagW;
   localparam int DivSteps  = QuotW;

   // multiply stage
   logic            m_vld_ff;
   logic [SqW-1:0]  sqre_ff, sqim_ff;
   logic            m_dc_ff;
   logic [ColW-1:0] m_col_ff;

   // square root stages, one result bit each
   logic            s_vld_ff  [SqrtSteps+1];
   logic [RadW-1:0] s_rem_ff  [SqrtSteps+1];
   logic [RadW-1:0] s_root_ff [SqrtSteps+1];
   logic [ColW-1:0] s_col_ff  [SqrtSteps+1];
   logic [RadW-1:0] s_rem_in  [SqrtSteps+1];
   logic [RadW-1:0] s_root_in [SqrtSteps+1];

   // divide stages, one quotient bit each
   logic             d_vld_ff [DivSteps+1];
   logic [MagW-1:0]  d_mag_ff [DivSteps+1];
   logic [MagW-1:0]  d_rem_ff [DivSteps+1];
   logic [QuotW-1:0] d_q_ff   [DivSteps+1];
   logic             d_sat_ff [DivSteps+1];
   logic [ColW-1:0]  d_col_ff [DivSteps+1];
   logic [MagW-1:0]  d_rem_in [DivSteps+1];
   logic [QuotW-1:0] d_q_in   [DivSteps+1];

   logic [SqW-1:0]   sq_sum;
   logic [RadW-1:0]  bitv, trial;
   logic [MagW-1:0]  mag_root, dsub;
   logic [DivW-1:0]  div_eff;
   logic [QuotW-1:0] q_eff;
   logic [RowW-1:0]  offset;

   always_comb begin
      sq_sum = sqre_ff + sqim_ff;
      s_rem_in[0] = m_dc_ff ? RadW'(sq_sum) : RadW'({sq_sum, 2'b00});
      s_root_in[0] = '0;
      for (int s = 0; s < SqrtSteps; s++) begin
         bitv = RadW'(1) << (2 * (SqrtSteps - 1 - s));
         trial = s_root_ff[s] + bitv;
         if (s_rem_ff[s] >= trial) begin
            s_rem_in[s+1] = s_rem_ff[s] - trial;
            s_root_in[s+1] = (s_root_ff[s] >> 1) + bitv;
         end else begin
            s_rem_in[s+1] = s_rem_ff[s];
            s_root_in[s+1] = s_root_ff[s] >> 1;
         end
      end

      div_eff = (cfg.divisor == '0) ? DivW'(1) : cfg.divisor;
      mag_root = s_root_ff[SqrtSteps][MagW-1:0];
      d_rem_in[0] = mag_root;
      d_q_in[0] = '0;
      for (int k = 0; k < DivSteps; k++) begin
         dsub = MagW'(div_eff) << (DivSteps - 1 - k);
         if (d_rem_ff[k] >= dsub) begin
            d_rem_in[k+1] = d_rem_ff[k] - dsub;
            d_q_in[k+1] = d_q_ff[k] | (QuotW'(1) << (DivSteps - 1 - k));
         end else begin
            d_rem_in[k+1] = d_rem_ff[k];
            d_q_in[k+1] = d_q_ff[k];
         end
      end

      q_eff = d_sat_ff[DivSteps] ? '1 : d_q_ff[DivSteps];
      offset = (cfg.half_height ? HalfLimit : FullLimit) - BarGap;
      out_word.magnitude = d_mag_ff[DivSteps];
      out_word.bar_top = (q_eff >= offset) ? '0 : offset - q_eff;
      out_word.column = d_col_ff[DivSteps];
   end

   always_ff @(posedge clock) begin
      sqre_ff <= SqW'(in_word.re_part * in_word.re_part);
      sqim_ff <= SqW'(in_word.im_part * in_word.im_part);
      m_dc_ff <= in_word.is_dc;
      m_col_ff <= in_word.column;

      s_rem_ff[0] <= s_rem_in[0];
      s_root_ff[0] <= s_root_in[0];
      s_col_ff[0] <= m_col_ff;
      for (int s = 0; s < SqrtSteps; s++) begin
         s_rem_ff[s+1] <= s_rem_in[s+1];
         s_root_ff[s+1] <= s_root_in[s+1];
         s_col_ff[s+1] <= s_col_ff[s];
      end

      d_mag_ff[0] <= mag_root;
      d_rem_ff[0] <= d_rem_in[0];
      d_q_ff[0] <= d_q_in[0];
      d_sat_ff[0] <= mag_root >= {MagW'(div_eff), QuotW'(0)} >> QuotW << QuotW;
      d_col_ff[0] <= s_col_ff[SqrtSteps];
      for (int k = 0; k < DivSteps; k++) begin
         d_mag_ff[k+1] <= d_mag_ff[k];
         d_rem_ff[k+1] <= d_rem_in[k+1];
         d_q_ff[k+1] <= d_q_in[k+1];
         d_sat_ff[k+1] <= d_sat_ff[k];
         d_col_ff[k+1] <= d_col_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_vld_ff <= 1'b0;
         for (int s = 0; s <= SqrtSteps; s++) begin
            s_vld_ff[s] <= 1'b0;
         end
         for (int k = 0; k <= DivSteps; k++) begin
            d_vld_ff[k] <= 1'b0;
         end
      end else begin
         m_vld_ff <= in_vld;
         s_vld_ff[0] <= m_vld_ff;
         for (int s = 0; s < SqrtSteps; s++) begin
            s_vld_ff[s+1] <= s_vld_ff[s];
         end
         d_vld_ff[0] <= s_vld_ff[SqrtSteps];
         for (int k = 0; k < DivSteps; k++) begin
            d_vld_ff[k+1] <= d_vld_ff[k];
         end
      end
   end

   assign out_vld = d_vld_ff[DivSteps];
endmodule

// File: rtl/sbph_queue.sv
`timescale 1ns / 1ps
module sbph_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  sbph_pkg::bar_word_type push_word,
   input  logic                   pop,
   output sbph_pkg::bar_word_type head,
   output sbph_pkg::q_status_type status
);
   import sbph_pkg::*;

   bar_word_type     mem_ff [QDepth];
   logic [QPtrW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCntW-1:0] cnt_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPtrW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPtrW'(1);
         end
         cnt_ff <= cnt_ff + QCntW'(push) - QCntW'(pop);
      end
   end

   assign head = mem_ff[rd_ptr_ff];
   assign status.nonempty = cnt_ff != '0;
   assign status.count = cnt_ff;
endmodule

// File: rtl/sbph_back.sv
`timescale 1ns / 1ps
module sbph_back (
   input  logic                   clock,
   input  logic                   reset,
   input  sbph_pkg::bar_word_type head,
   input  logic                   head_vld,
   output logic                   pop,
   input  sbph_pkg::cfg_type      cfg,
   sbph_rsp_if.source             rsp
);
   import sbph_pkg::*;

   logic                  adv, wr_en, in_rng;
   logic [ColAddrW-1:0]   rd_addr, wr_addr;
   logic [PeakW-1:0]      rd_data, p, yy, lim, pc, new_p;
   logic                  vis;
   logic [RowW-1:0]       prow;
   logic [NumColumns-1:0] pvld_ff;
   logic                  b_vld_ff, b_rng_ff, fwd_ff, vrd_ff;
   bar_word_type          b_word_ff;
   logic [PeakW-1:0]      fwd_data_ff;
   logic                  out_vld_ff, out_vis_ff;
   logic [MagW-1:0]       out_mag_ff;
   logic [RowW-1:0]       out_top_ff, out_prow_ff;

   assign adv = !out_vld_ff || rsp.ready;
   assign pop = adv && head_vld;
   assign rd_addr = ColAddrW'(head.column);
   assign wr_addr = ColAddrW'(b_word_ff.column);
   assign in_rng = 32'(head.column) < NumColumns;

   sbph_ram #(.Width(PeakW), .Depth(NumColumns)) u_peak_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (new_p),
      .rd_en   (pop),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      p = fwd_ff ? fwd_data_ff : (vrd_ff ? rd_data : PeakW'(FullLimit));
      yy = PeakW'(b_word_ff.bar_top);
      lim = PeakW'(cfg.half_height ? HalfLimit : FullLimit);
      pc = (p > lim) ? lim : p;
      if (p > yy) begin
         new_p = yy;
         vis = 1'b0;
         prow = b_word_ff.bar_top;
      end else begin
         new_p = pc + PeakW'(cfg.fall_step);
         vis = 1'b1;
         prow = pc[RowW-1:0];
      end
      if (!b_rng_ff) begin
         vis = 1'b0;
         prow = '0;
      end
      wr_en = adv && b_vld_ff && b_rng_ff;
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         b_word_ff <= head;
         b_rng_ff <= in_rng;
         vrd_ff <= pvld_ff[rd_addr];
         fwd_data_ff <= new_p;
      end
      if (adv) begin
         out_mag_ff <= b_word_ff.magnitude;
         out_top_ff <= b_word_ff.bar_top;
         out_vis_ff <= vis;
         out_prow_ff <= prow;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pvld_ff <= '0;
         b_vld_ff <= 1'b0;
         fwd_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            pvld_ff[wr_addr] <= 1'b1;
         end
         if (pop) begin
            fwd_ff <= wr_en && (wr_addr == rd_addr);
         end
         if (adv) begin
            b_vld_ff <= pop;
            out_vld_ff <= b_vld_ff;
         end
      end
   end

   assign rsp.valid = out_vld_ff;
   assign rsp.magnitude = out_mag_ff;
   assign rsp.bar_top = out_top_ff;
   assign rsp.peak_visible = out_vis_ff;
   assign rsp.peak_row = out_prow_ff;
endmodule
